[rtl/core/hrp_pkg.sv]
// hex record parser package: phase codes, status codes, result types and nibble decode
package hrp_pkg;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    localparam logic [1:0] ST_DATA       = 2'd0;
    localparam logic [1:0] ST_ZERO_COUNT = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE   = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_byte;
        logic [15:0] line_address;
        logic [7:0]  byte_index;
        logic        last_of_line;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_result_req;

    function automatic logic [3:0] nib_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
        end
        return t[3:0];
    endfunction

endpackage

[rtl/core/hrp_if.sv]
// request channel interfaces for the hex record parser
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       line_start;

    modport source (output valid, output ascii_char, output line_start, input ready);
    modport sink   (input valid, input ascii_char, input line_start, output ready);
endinterface

interface hrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [15:0] line_address;
    logic [7:0]  byte_index;
    logic        last_of_line;

    modport source (output valid, output status, output data_byte, output line_address,
                    output byte_index, output last_of_line, input ready);
    modport sink   (input valid, input status, input data_byte, input line_address,
                    input byte_index, input last_of_line, output ready);
endinterface

[rtl/core/hex_record_parser_top.sv]
// hex record parser top level: field sequencer and result register
//
// channel   dir  payload                                                     ready rule
// i_in      in   ascii_char, line_start                                      out reg free or taken
// o_out     out  status, data_byte, line_address, byte_index, last_of_line   from sink
//
// one character is taken each cycle while i_in.ready is high; its result, if any, shows the next cycle
// the rate is set by the result register, which is reloaded in the cycle it is taken
// i_rst_n synchronous, active low, returns the parser to idle with no result pending
// a stalled result holds; input stalls only while that result is held
module hex_record_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hrp_in_if.sink        i_in,
    hrp_out_if.source     o_out
);

    logic                 in_fire;
    hrp_pkg::t_result_req res;

    logic                 r_out_valid, n_out_valid;
    hrp_pkg::t_result     r_out, n_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    hrp_field_ctl u_field_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_ascii_char (i_in.ascii_char),
        .i_line_start (i_in.line_start),
        .o_res        (res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res.valid) begin
            n_out_valid = 1'b1;
            n_out       = res.result;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.data_byte    = r_out.data_byte;
    assign o_out.line_address = r_out.line_address;
    assign o_out.byte_index   = r_out.byte_index;
    assign o_out.last_of_line = r_out.last_of_line;

    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != hrp_pkg::ST_DATA |-> r_out.last_of_line)
        else $error("rejection without last mark");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !r_out_valid || o_out.ready)
        else $error("pending result overwritten");

endmodule

[rtl/core/hrp_field_ctl.sv]
// record field sequencer: nibble pairing, header capture, and data byte and rejection results
module hrp_field_ctl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_ascii_char,
    input  logic                 i_line_start,
    output hrp_pkg::t_result_req o_res
);

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_high, n_high;
    logic        r_tog, n_tog;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_addr, n_addr;
    logic        r_abc, n_abc;
    logic [7:0]  r_pos, n_pos;

    logic [2:0]  eff_phase;
    logic        eff_tog;
    logic        eff_abc;
    logic [7:0]  eff_pos;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic        is_last;
    logic        active;

    always_comb begin
        eff_phase = i_line_start ? hrp_pkg::PH_COUNT : r_phase;
        eff_tog   = i_line_start ? 1'b0 : r_tog;
        eff_abc   = i_line_start ? 1'b0 : r_abc;
        eff_pos   = i_line_start ? 8'd0 : r_pos;
        nib       = hrp_pkg::nib_of(i_ascii_char);
        byte_val  = {r_high, nib};
        is_last   = ({1'b0, eff_pos} + 9'd1) == {1'b0, r_len};
        active    = eff_phase == hrp_pkg::PH_COUNT || eff_phase == hrp_pkg::PH_ADDR ||
                    eff_phase == hrp_pkg::PH_TYPE  || eff_phase == hrp_pkg::PH_DATA;
    end

    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        n_tog   = r_tog;
        n_len   = r_len;
        n_addr  = r_addr;
        n_abc   = r_abc;
        n_pos   = r_pos;
        o_res   = '0;
        if (i_fire) begin
            n_phase = eff_phase;
            n_tog   = eff_tog;
            n_abc   = eff_abc;
            n_pos   = eff_pos;
            if (active) begin
                if (!eff_tog) begin
                    n_high = nib;
                    n_tog  = 1'b1;
                end else begin
                    n_tog = 1'b0;
                    unique case (eff_phase)
                        hrp_pkg::PH_COUNT: begin
                            n_len = byte_val;
                            if (byte_val == 8'd0) begin
                                n_phase                   = hrp_pkg::PH_DONE;
                                o_res.valid               = 1'b1;
                                o_res.result.status       = hrp_pkg::ST_ZERO_COUNT;
                                o_res.result.last_of_line = 1'b1;
                            end else begin
                                n_phase = hrp_pkg::PH_ADDR;
                            end
                        end
                        hrp_pkg::PH_ADDR: begin
                            if (!eff_abc) begin
                                n_addr = {byte_val, 8'h00};
                                n_abc  = 1'b1;
                            end else begin
                                n_addr  = {r_addr[15:8], byte_val};
                                n_phase = hrp_pkg::PH_TYPE;
                            end
                        end
                        hrp_pkg::PH_TYPE: begin
                            if (byte_val != 8'd0) begin
                                n_phase                   = hrp_pkg::PH_DONE;
                                o_res.valid               = 1'b1;
                                o_res.result.status       = hrp_pkg::ST_BAD_TYPE;
                                o_res.result.line_address = r_addr;
                                o_res.result.last_of_line = 1'b1;
                            end else begin
                                n_phase = hrp_pkg::PH_DATA;
                            end
                        end
                        default: begin
                            o_res.valid               = 1'b1;
                            o_res.result.status       = hrp_pkg::ST_DATA;
                            o_res.result.data_byte    = byte_val;
                            o_res.result.line_address = r_addr;
                            o_res.result.byte_index   = eff_pos;
                            o_res.result.last_of_line = is_last;
                            n_pos = eff_pos + 8'd1;
                            if (is_last) begin
                                n_phase = hrp_pkg::PH_DONE;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrp_pkg::PH_IDLE;
            r_high  <= 4'd0;
            r_tog   <= 1'b0;
            r_len   <= 8'd0;
            r_addr  <= 16'd0;
            r_abc   <= 1'b0;
            r_pos   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_tog   <= n_tog;
            r_len   <= n_len;
            r_addr  <= n_addr;
            r_abc   <= n_abc;
            r_pos   <= n_pos;
        end
    end

    a_last_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.result.last_of_line |=> r_phase == hrp_pkg::PH_DONE)
        else $error("record not closed after last result");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.result.status == hrp_pkg::ST_DATA |->
            o_res.result.byte_index < r_len)
        else $error("data byte index beyond record length");

    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hrp_pkg::PH_IDLE || r_phase == hrp_pkg::PH_DONE) && !i_line_start
            |-> !o_res.valid)
        else $error("result outside a record");

endmodule
